[hw/rtl/rffa_pkg.sv]
// Shared types, constants and helper functions of the random free-frame allocator.
package rffa_pkg;

  localparam int unsigned MAX_FRAMES = 32;
  localparam int unsigned IDX_W      = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned LFSR_W     = 32;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

  // Remainder unit: dividend bits consumed per cycle, steps per remainder
  localparam int unsigned MOD_STEP   = 8;
  localparam int unsigned MOD_CYCLES = LFSR_W / MOD_STEP;
  localparam int unsigned MOD_CNT_W  = $clog2(MOD_CYCLES);

  // Frame zero is reserved after reset
  localparam logic [MAX_FRAMES-1:0] USED_RESET = {{(MAX_FRAMES-1){1'b0}}, 1'b1};

  localparam int unsigned CFG_IDX_W = 4;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MANAGED_FRAMES = 4'd0,
    REG_RANDOM_SEED    = 4'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    ACT_ALLOCATE = 2'd0,
    ACT_RELEASE  = 2'd1,
    ACT_QUERY    = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } status_t;

  // One Galois LFSR shift
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

  // A zero seed would lock the LFSR
  function automatic logic [LFSR_W-1:0] seed_fix(input logic [LFSR_W-1:0] s);
    return (s == '0) ? LFSR_W'(1) : s;
  endfunction

  // Clamp the managed-frame register into 1..MAX_FRAMES
  function automatic logic [CNT_W-1:0] clamp_count(input logic [5:0] m);
    logic [CNT_W-1:0] r;
    if (m == 6'd0) begin
      r = CNT_W'(1);
    end else if (32'(m) > MAX_FRAMES) begin
      r = CNT_W'(MAX_FRAMES);
    end else begin
      r = CNT_W'(m);
    end
    return r;
  endfunction

endpackage

[hw/rtl/rffa_modulo.sv]
// Iterative remainder unit: 32-bit value mod a small divisor, eight bits per cycle.
module rffa_modulo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rffa_pkg::LFSR_W-1:0]    dividend,
  input  logic [rffa_pkg::CNT_W-1:0]     divisor,
  output logic                           done,
  output logic [rffa_pkg::CNT_W-1:0]     remainder
);

  logic                              busy;
  logic [rffa_pkg::MOD_CNT_W-1:0]    step_cnt;
  logic [rffa_pkg::LFSR_W-1:0]       shreg;
  logic [rffa_pkg::CNT_W-1:0]        div;
  logic [rffa_pkg::CNT_W-1:0]        rem;
  logic [rffa_pkg::CNT_W-1:0]        rem_next;

  // Restoring remainder steps over the top bits of the shift register
  always_comb begin
    logic [rffa_pkg::CNT_W:0] r;
    r = {1'b0, rem};
    for (int k = 0; k < rffa_pkg::MOD_STEP; k++) begin
      r = {r[rffa_pkg::CNT_W-1:0], shreg[rffa_pkg::LFSR_W-1-k]};
      if (r >= {1'b0, div}) begin
        r = r - {1'b0, div};
      end
    end
    rem_next = r[rffa_pkg::CNT_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      done     <= 1'b0;
      step_cnt <= '0;
    end else if (busy) begin
      step_cnt <= step_cnt + 1'b1;
      if (step_cnt == rffa_pkg::MOD_CNT_W'(rffa_pkg::MOD_CYCLES - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      div   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << rffa_pkg::MOD_STEP;
      rem   <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

[hw/rtl/random_free_frame_allocator.sv]
// Top level of the random free-frame allocator: sequencer, frame map and output register.
// One bit per frame marks it used; frame 0 is reserved after reset. Allocate scans the
// managed frames from 0 upward and picks one free frame uniformly by reservoir sampling,
// stepping a 32-bit Galois LFSR once per free frame and testing the value mod the running
// free count with an iterative remainder unit. Every action closes with a count of free
// frames that walks the map one frame per cycle. The input is taken again only after the
// result is in the output register, which holds it until the sink takes it.
module random_free_frame_allocator (
  input  logic                               clk,
  input  logic                               rst,
  // Input items
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // action[1:0], frame_index[6:2]
  // Result items
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [15:0]                        m_tdata,   // granted_frame[4:0], status[6:5],
                                                        // free_frames[12:7]
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rffa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_MOD   = 5'b00100,
    S_COUNT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                              state;
  logic [5:0]                          managed_frames;
  logic [rffa_pkg::LFSR_W-1:0]         random_state;
  logic [rffa_pkg::MAX_FRAMES-1:0]     used_map;
  logic [rffa_pkg::CNT_W-1:0]          n_active;
  logic [rffa_pkg::CNT_W-1:0]          pos;
  logic [rffa_pkg::CNT_W-1:0]          seen;
  logic [rffa_pkg::CNT_W-1:0]          free_cnt;
  logic [rffa_pkg::IDX_W-1:0]          pick;
  logic                                found;
  logic [rffa_pkg::IDX_W-1:0]          granted;
  rffa_pkg::status_t                   status;

  logic                                accept;
  logic [1:0]                          in_action;
  logic [rffa_pkg::IDX_W-1:0]          in_index;
  logic [rffa_pkg::CNT_W-1:0]          n_now;
  logic [rffa_pkg::IDX_W-1:0]          pos_idx;
  logic                                pos_end;
  logic [rffa_pkg::LFSR_W-1:0]         lfsr_next;
  logic                                mod_start;
  logic                                mod_done;
  logic [rffa_pkg::CNT_W-1:0]          mod_rem;
  logic                                out_load;

  assign in_action = s_tdata[1:0];
  assign in_index  = s_tdata[6:2];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign n_now     = rffa_pkg::clamp_count(managed_frames);
  assign pos_idx   = pos[rffa_pkg::IDX_W-1:0];
  assign pos_end   = (pos == n_active);
  assign lfsr_next = rffa_pkg::lfsr_step(random_state);
  assign mod_start = (state == S_SCAN) && !pos_end && !used_map[pos_idx];
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);

  rffa_modulo u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (lfsr_next),
    .divisor   (seen + 1'b1),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Configuration registers and LFSR
  always_ff @(posedge clk) begin
    if (rst) begin
      managed_frames <= 6'(rffa_pkg::MAX_FRAMES);
      random_state   <= rffa_pkg::LFSR_W'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rffa_pkg::REG_MANAGED_FRAMES: managed_frames <= cfg_data[5:0];
          rffa_pkg::REG_RANDOM_SEED:    random_state   <= rffa_pkg::seed_fix(cfg_data);
          default: ;
        endcase
      end
      if (mod_start) begin
        random_state <= lfsr_next;
      end
    end
  end

  // Frame map
  always_ff @(posedge clk) begin
    if (rst) begin
      used_map <= rffa_pkg::USED_RESET;
    end else if (accept && in_action == rffa_pkg::ACT_RELEASE &&
                 {1'b0, in_index} < n_now) begin
      used_map[in_index] <= 1'b0;
    end else if (state == S_SCAN && pos_end && found) begin
      used_map[pick] <= 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (in_action == rffa_pkg::ACT_ALLOCATE) ? S_SCAN : S_COUNT;
          end
        end
        S_SCAN: begin
          if (pos_end) begin
            state <= S_COUNT;
          end else if (!used_map[pos_idx]) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_SCAN;
          end
        end
        S_COUNT: begin
          if (pos_end) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        n_active <= n_now;
        pos      <= '0;
        seen     <= '0;
        found    <= 1'b0;
        free_cnt <= '0;
        granted  <= '0;
        status   <= rffa_pkg::ST_OK;
        if (in_action == rffa_pkg::ACT_RELEASE && {1'b0, in_index} >= n_now) begin
          status <= rffa_pkg::ST_OUT_OF_RANGE;
        end
      end
      S_SCAN: begin
        if (pos_end) begin
          pos <= '0;
          if (found) begin
            granted <= pick;
          end else begin
            status <= rffa_pkg::ST_NO_FREE;
          end
        end else if (used_map[pos_idx]) begin
          pos <= pos + 1'b1;
        end else begin
          seen <= seen + 1'b1;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          if (mod_rem == '0) begin
            pick  <= pos_idx;
            found <= 1'b1;
          end
          pos <= pos + 1'b1;
        end
      end
      S_COUNT: begin
        if (!pos_end) begin
          pos <= pos + 1'b1;
          if (!used_map[pos_idx]) begin
            free_cnt <= free_cnt + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, free_cnt, status, granted};
    end
  end

endmodule
